// File: rtl/css_escape_serializer_defines.svh
// Assertion macros for the CSS escape serializer.
// Included by the top level; relies on clk and rst in the including scope.
`ifndef CSS_ESCAPE_SERIALIZER_DEFINES_SVH
`define CSS_ESCAPE_SERIALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ces_pkg.sv
// Shared types and constants for the CSS escape serializer.
// Used by the front end, the request queue, the back end and the top level.
`default_nettype none

package ces_pkg;

  localparam int UNIT_W          = 16;
  localparam int MAX_UNITS       = 6;
  localparam int CNT_W           = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  typedef enum logic {
    REG_IDENT_MODE = 1'b0,
    REG_QUOTE_APOS = 1'b1
  } ces_reg_t;

  // Characters that the escaper emits or tests
  localparam logic [UNIT_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [UNIT_W-1:0] CH_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [UNIT_W-1:0] CH_APOS   = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_DASH   = 16'h002D;
  localparam logic [UNIT_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] CH_DEL    = 16'h007F;
  localparam logic [UNIT_W-1:0] CH_REPL   = 16'hFFFD;

  // One classified request: the escaped units it expands to
  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
    logic [CNT_W-1:0]                 cnt;
    logic                             done;
  } ces_desc_t;

  typedef struct packed {
    logic      valid;
    ces_desc_t desc;
  } ces_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ces_qstat_t;

endpackage

`default_nettype wire

// File: rtl/ces_front.sv
// Front end: holds configuration and string state, classifies each request
// into its list of escaped units. Depends on ces_pkg.
`default_nettype none

module ces_front import ces_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic              wr_data,
  input  wire logic              in_valid,
  input  wire logic [UNIT_W-1:0] code_unit,
  input  wire logic              string_last,
  input  wire logic              empty_string,
  input  wire ces_qstat_t        q_status,
  output logic                   in_stall,
  output ces_push_t              push_req
);

  logic ident_mode;
  logic quote_apostrophe;
  logic at_string_start;
  logic after_leading_dash;
  logic at_string_start_next;
  logic after_leading_dash_next;

  logic              accept;
  logic [UNIT_W-1:0] quote;
  logic              is_digit;
  logic              is_ctrl;
  logic              is_ident_ascii;
  logic              pre_q;
  logic              numeric;
  logic              bs;
  logic              emit_ch;
  logic [UNIT_W-1:0] ch;
  logic              suf_q;
  logic              eff_last;
  logic [CNT_W-1:0]  n;
  logic [MAX_UNITS-1:0][UNIT_W-1:0] units;

  function automatic logic [UNIT_W-1:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return UNIT_W'(16'h0030 + {12'h000, v});
    end
    return UNIT_W'(16'h0057 + {12'h000, v});
  endfunction

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign quote    = quote_apostrophe ? CH_APOS : CH_DQUOTE;

  // Character classes
  always_comb begin
    is_digit = (code_unit >= 16'h0030) && (code_unit <= 16'h0039);
    is_ctrl  = (code_unit < CH_SPACE) || (code_unit == CH_DEL);
    is_ident_ascii = (code_unit == 16'h005F) || (code_unit == CH_DASH) || is_digit ||
                     ((code_unit >= 16'h0041) && (code_unit <= 16'h005A)) ||
                     ((code_unit >= 16'h0061) && (code_unit <= 16'h007A));
  end

  // Decide which pieces this request emits, and the next string state
  always_comb begin
    pre_q    = 1'b0;
    numeric  = 1'b0;
    bs       = 1'b0;
    emit_ch  = 1'b0;
    ch       = code_unit;
    suf_q    = 1'b0;
    eff_last = string_last || empty_string;
    at_string_start_next    = at_string_start;
    after_leading_dash_next = after_leading_dash;
    if (empty_string) begin
      if (!ident_mode) begin
        pre_q = at_string_start;
        suf_q = 1'b1;
      end
    end else if (!ident_mode) begin
      after_leading_dash_next = 1'b0;
      pre_q = at_string_start;
      if (is_ctrl) begin
        numeric = 1'b1;
      end else begin
        bs = (code_unit == CH_DQUOTE) || (code_unit == CH_APOS) ||
             (code_unit == CH_BSLASH);
        emit_ch = 1'b1;
      end
      suf_q = string_last;
    end else begin
      if (after_leading_dash && !at_string_start) begin
        after_leading_dash_next = 1'b0;
      end
      if (at_string_start && (code_unit == CH_DASH)) begin
        emit_ch = 1'b1;
        if (string_last) begin
          bs = 1'b1;
        end else begin
          after_leading_dash_next = 1'b1;
        end
      end else if ((at_string_start || after_leading_dash) && is_digit) begin
        numeric = 1'b1;
      end else if (code_unit == CH_NUL) begin
        emit_ch = 1'b1;
        ch      = CH_REPL;
      end else if (is_ctrl) begin
        numeric = 1'b1;
      end else begin
        bs      = (code_unit < CH_DEL) && !is_ident_ascii;
        emit_ch = 1'b1;
      end
    end
    if (!empty_string) begin
      at_string_start_next = 1'b0;
    end
    if (eff_last) begin
      at_string_start_next    = 1'b1;
      after_leading_dash_next = 1'b0;
    end
  end

  // Pack the pieces into consecutive unit slots
  always_comb begin
    units = '0;
    n     = '0;
    if (pre_q) begin
      units[n] = quote;
      n = n + 1'b1;
    end
    if (numeric) begin
      units[n] = CH_BSLASH;
      n = n + 1'b1;
      if (code_unit[6:4] != 3'd0) begin
        units[n] = hex_digit(code_unit[7:4]);
        n = n + 1'b1;
      end
      units[n] = hex_digit(code_unit[3:0]);
      n = n + 1'b1;
      units[n] = CH_SPACE;
      n = n + 1'b1;
    end
    if (bs) begin
      units[n] = CH_BSLASH;
      n = n + 1'b1;
    end
    if (emit_ch) begin
      units[n] = ch;
      n = n + 1'b1;
    end
    if (suf_q) begin
      units[n] = quote;
      n = n + 1'b1;
    end
  end

  // Drop requests that expand to nothing
  always_comb begin
    push_req.valid      = accept && (n != '0);
    push_req.desc.units = units;
    push_req.desc.cnt   = n;
    push_req.desc.done  = eff_last;
  end

  // Hold configuration and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      ident_mode         <= 1'b0;
      quote_apostrophe   <= 1'b0;
      at_string_start    <= 1'b1;
      after_leading_dash <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_IDENT_MODE: ident_mode       <= wr_data;
          REG_QUOTE_APOS: quote_apostrophe <= wr_data;
          default: ;
        endcase
      end
      if (accept) begin
        at_string_start    <= at_string_start_next;
        after_leading_dash <= after_leading_dash_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ces_queue.sv
// Request queue between front and back end: a small circular buffer.
// Depends on ces_pkg for the request type.
`default_nettype none

module ces_queue import ces_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ces_push_t  push_req,
  input  wire logic       pop,
  output ces_desc_t       head,
  output ces_qstat_t      q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W2 = $clog2(DEPTH + 1);

  ces_desc_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W2-1:0]  count;

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == CNT_W2'(DEPTH));
  assign q_status.empty = (count == '0);

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push_req.valid) begin
      mem[wr_ptr] <= push_req.desc;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_req.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_req.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push_req.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ces_back.sv
// Back end: walks the head request one unit per cycle, while the output is not
// stalled, into the output register. Depends on ces_pkg.
`default_nettype none

module ces_back import ces_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ces_desc_t         head,
  input  wire ces_qstat_t        q_status,
  input  wire logic              out_stall,
  output logic                   pop,
  output logic                   out_valid,
  output logic [UNIT_W-1:0]      out_unit,
  output logic                   run_last,
  output logic                   text_done
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             final_unit;

  assign load       = !q_status.empty && (!out_valid || !out_stall);
  assign final_unit = ((idx + 1'b1) == head.cnt);
  assign pop        = load && final_unit;

  // Advance the unit index within the head request
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= final_unit ? '0 : idx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_unit  <= head.units[idx];
      run_last  <= final_unit;
      text_done <= final_unit && head.done;
    end
  end

endmodule

`default_nettype wire

// File: rtl/css_escape_serializer.sv
// CSS escape serializer: takes one UTF-16 code unit per request and emits its
// escaped CSS form (quoted string or identifier, chosen by ident_mode) one unit
// per output request. The front end accepts one request per cycle while the
// QUEUE_DEPTH-entry request queue has room; the back end emits one unit per
// cycle while out_stall does not hold it, and a request expands to 1 to 6 units
// (a plain character 1, a control escaped with quotes up to 6). Requests that
// expand to nothing (empty string in identifier mode) are accepted but not
// queued. run_last marks the last unit of each request, text_done the last
// unit of the whole escaped string. The first unit of a request passes through
// the request queue and then the output register before it is presented.
`default_nettype none
`include "css_escape_serializer_defines.svh"

module css_escape_serializer import ces_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic              wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [UNIT_W-1:0] code_unit,
  input  wire logic              string_last,
  input  wire logic              empty_string,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [UNIT_W-1:0]      out_unit,
  output logic                   run_last,
  output logic                   text_done
);

  ces_push_t  push_req;
  ces_qstat_t q_status;
  ces_desc_t  head;
  logic       pop;

  ces_front u_front (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .code_unit    (code_unit),
    .string_last  (string_last),
    .empty_string (empty_string),
    .q_status     (q_status),
    .in_stall     (in_stall),
    .push_req     (push_req)
  );

  ces_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  ces_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_unit  (out_unit),
    .run_last  (run_last),
    .text_done (text_done)
  );

  // Queue never overflows, never underflows, end of text closes a request, and a push shows in the queue status
  `CES_ASSERT_NOW(a_no_overflow, push_req.valid, !q_status.full, "queue push while full")
  `CES_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "queue pop while empty")
  `CES_ASSERT_NOW(a_done_is_last, out_valid && text_done, run_last, "text_done without run_last")
  `CES_ASSERT_NEXT(a_fill_shows, push_req.valid, !q_status.empty, "pushed request not visible")

endmodule

`default_nettype wire
